/* src/linear_program_evaluator_macros.svh */
// assertion macros for the linear program evaluator checker
// needs clk_i and rst_ni in the scope of each use
`ifndef LINEAR_PROGRAM_EVALUATOR_MACROS_SVH
`define LINEAR_PROGRAM_EVALUATOR_MACROS_SVH

// concurrent property on the rising clock, off while in reset
`define LPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// a condition that must never be seen outside reset
`define LPE_ASSERT_NEVER(label, expr, msg) \
  `LPE_ASSERT(label, !(expr), msg)

`endif

/* src/lpe_pkg.sv */
// shared types, opcodes and constants of the linear program evaluator
// no dependencies
package lpe_pkg;

  localparam int unsigned PROGRAM_BITS          = 56;
  localparam int unsigned SLOT_BITS             = 7;
  localparam int unsigned LENGTH_BITS           = 4;
  localparam int unsigned FIELD_BITS            = 8;
  localparam int unsigned REG_COUNT             = 4;
  localparam int unsigned PROGRAM_SLOTS_DEFAULT = 8;
  localparam int unsigned VALUE_BITS_DEFAULT    = 8;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_JMPIFZ = 3'd2,
    OP_LDIM   = 3'd3,
    OP_SHL    = 3'd4,
    OP_SHR    = 3'd5,
    OP_NOP    = 3'd6,
    OP_HALT   = 3'd7
  } lpe_op_e;

  typedef struct packed {
    logic [PROGRAM_BITS-1:0]      program_req;
    logic [LENGTH_BITS-1:0]       length;
    logic signed [FIELD_BITS-1:0] const_zero;
    logic signed [FIELD_BITS-1:0] const_one;
    logic signed [FIELD_BITS-1:0] const_two;
    logic signed [FIELD_BITS-1:0] const_three;
    logic signed [FIELD_BITS-1:0] input_a;
    logic signed [FIELD_BITS-1:0] input_b;
    logic signed [FIELD_BITS-1:0] expected;
  } lpe_req_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] result;
    logic [FIELD_BITS-1:0]        abs_error;
    logic                         halted;
  } lpe_rsp_t;

  // per-stage control that travels down the slot pipeline
  typedef struct packed {
    logic                   valid;
    logic                   halted;
    logic [LENGTH_BITS-1:0] length;
  } lpe_ctrl_t;

endpackage

/* src/lpe_slot.sv */
// one pipeline stage that executes one instruction slot of the program
// depends on lpe_pkg
module lpe_slot #(
  parameter int unsigned VALUE_BITS = lpe_pkg::VALUE_BITS_DEFAULT,
  parameter int unsigned SLOT_INDEX = 0
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  lpe_pkg::lpe_ctrl_t                             ctrl_i,
  input  logic [lpe_pkg::PROGRAM_BITS-1:0]               program_i,
  input  logic [lpe_pkg::REG_COUNT-1:0][VALUE_BITS-1:0]  regs_i,
  input  logic [lpe_pkg::REG_COUNT-1:0][VALUE_BITS-1:0]  consts_i,
  input  logic [lpe_pkg::FIELD_BITS-1:0]                 expected_i,
  output lpe_pkg::lpe_ctrl_t                             ctrl_o,
  output logic [lpe_pkg::PROGRAM_BITS-1:0]               program_o,
  output logic [lpe_pkg::REG_COUNT-1:0][VALUE_BITS-1:0]  regs_o,
  output logic [lpe_pkg::REG_COUNT-1:0][VALUE_BITS-1:0]  consts_o,
  output logic [lpe_pkg::FIELD_BITS-1:0]                 expected_o
);
  import lpe_pkg::*;

  localparam bit SlotInField = ((SLOT_INDEX + 1) * SLOT_BITS) <= PROGRAM_BITS;

  logic [SLOT_BITS-1:0] word;
  lpe_op_e              op;
  logic [1:0]           dst;
  logic [1:0]           src;
  logic                 active;

  lpe_ctrl_t                                ctrl_d, ctrl_q;
  logic [REG_COUNT-1:0][VALUE_BITS-1:0]     regs_d, regs_q;
  logic [PROGRAM_BITS-1:0]                  program_q;
  logic [REG_COUNT-1:0][VALUE_BITS-1:0]     consts_q;
  logic [FIELD_BITS-1:0]                    expected_q;

  // slots above the program field read as all zero
  generate
    if (SlotInField) begin : g_slot
      assign word = program_i[SLOT_INDEX*SLOT_BITS +: SLOT_BITS];
    end else begin : g_blank
      assign word = '0;
    end
  endgenerate

  assign op     = lpe_op_e'(word[2:0]);
  assign dst    = word[4:3];
  assign src    = word[6:5];
  assign active = ctrl_i.valid && !ctrl_i.halted &&
                  (LENGTH_BITS'(SLOT_INDEX) < ctrl_i.length);

  always_comb begin
    regs_d = regs_i;
    ctrl_d = ctrl_i;
    if (active) begin
      unique case (op)
        OP_ADD:    regs_d[dst] = regs_i[dst] + regs_i[src];
        OP_SUB:    regs_d[dst] = regs_i[dst] - regs_i[src];
        OP_LDIM:   regs_d[dst] = consts_i[src];
        OP_SHL:    regs_d[dst] = {regs_i[dst][VALUE_BITS-2:0], 1'b0};
        OP_SHR:    regs_d[dst] = $signed(regs_i[dst]) >>> 1;
        // halt value moves to register 0, later slots stay idle
        OP_HALT: begin
          regs_d[0]     = regs_i[dst];
          ctrl_d.halted = 1'b1;
        end
        OP_JMPIFZ: regs_d = regs_i;
        OP_NOP:    regs_d = regs_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    regs_q     <= regs_d;
    program_q  <= program_i;
    consts_q   <= consts_i;
    expected_q <= expected_i;
  end

  assign ctrl_o     = ctrl_q;
  assign program_o  = program_q;
  assign regs_o     = regs_q;
  assign consts_o   = consts_q;
  assign expected_o = expected_q;

endmodule

/* src/linear_program_evaluator.sv */
// top level of the linear program evaluator: slot pipeline plus error stages
// depends on lpe_pkg and lpe_slot
//
//   channel   handshake        payload          direction
//   request   start / busy     req_i (beat)     in
//   response  done_o strobe    rsp_o (beat)     out
//
// one request beat is taken in every cycle; busy stays low
// there is one register stage per instruction slot, then a subtract stage
// and an absolute value / saturate stage
// the response is shown for exactly one cycle with done_o and is not held
// reset clears the valid bits of every stage; data registers are not reset
module linear_program_evaluator #(
  parameter int unsigned PROGRAM_SLOTS = lpe_pkg::PROGRAM_SLOTS_DEFAULT,
  parameter int unsigned VALUE_BITS    = lpe_pkg::VALUE_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lpe_pkg::lpe_req_t req_i,
  output logic              done_o,
  output lpe_pkg::lpe_rsp_t rsp_o
);
  import lpe_pkg::*;

  // wide enough for the difference of a value and an 8-bit expected value
  localparam int unsigned DiffBits = ((VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS) + 1;

  // stage k feeds slot k; entry PROGRAM_SLOTS is the last slot's output
  lpe_ctrl_t                               ctrl     [PROGRAM_SLOTS+1];
  logic [PROGRAM_BITS-1:0]                 prog     [PROGRAM_SLOTS+1];
  logic [REG_COUNT-1:0][VALUE_BITS-1:0]    regs     [PROGRAM_SLOTS+1];
  logic [REG_COUNT-1:0][VALUE_BITS-1:0]    consts   [PROGRAM_SLOTS+1];
  logic [FIELD_BITS-1:0]                   expected [PROGRAM_SLOTS+1];

  // subtract stage
  logic                          diff_valid_q;
  logic                          diff_halted_q;
  logic signed [DiffBits-1:0]    diff_d, diff_q;
  logic signed [FIELD_BITS-1:0]  result_q;

  // output stage
  logic [DiffBits-1:0]  magnitude;
  logic                 done_q;
  lpe_rsp_t             rsp_d, rsp_q;

  // the pipeline never stalls
  assign busy = 1'b0;

  // entry: fields wrap to the value width, registers 2 and 3 start at zero
  assign ctrl[0].valid  = start && !busy;
  assign ctrl[0].halted = 1'b0;
  assign ctrl[0].length = req_i.length;
  assign prog[0]        = req_i.program_req;
  assign expected[0]    = req_i.expected;
  assign regs[0][0]     = VALUE_BITS'(req_i.input_a);
  assign regs[0][1]     = VALUE_BITS'(req_i.input_b);
  assign regs[0][2]     = '0;
  assign regs[0][3]     = '0;
  assign consts[0][0]   = VALUE_BITS'(req_i.const_zero);
  assign consts[0][1]   = VALUE_BITS'(req_i.const_one);
  assign consts[0][2]   = VALUE_BITS'(req_i.const_two);
  assign consts[0][3]   = VALUE_BITS'(req_i.const_three);

  // one stage per slot; a length above the slot count simply runs every slot
  generate
    for (genvar k = 0; k < PROGRAM_SLOTS; k++) begin : g_slots
      lpe_slot #(
        .VALUE_BITS (VALUE_BITS),
        .SLOT_INDEX (k)
      ) u_slot (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl[k]),
        .program_i  (prog[k]),
        .regs_i     (regs[k]),
        .consts_i   (consts[k]),
        .expected_i (expected[k]),
        .ctrl_o     (ctrl[k+1]),
        .program_o  (prog[k+1]),
        .regs_o     (regs[k+1]),
        .consts_o   (consts[k+1]),
        .expected_o (expected[k+1])
      );
    end
  endgenerate

  // register 0 holds the returned value, whether halted or run off the end
  assign diff_d = DiffBits'($signed(regs[PROGRAM_SLOTS][0]))
                - DiffBits'($signed(expected[PROGRAM_SLOTS]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_valid_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      diff_valid_q <= ctrl[PROGRAM_SLOTS].valid;
      done_q       <= diff_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q        <= diff_d;
    diff_halted_q <= ctrl[PROGRAM_SLOTS].halted;
    result_q      <= FIELD_BITS'($signed(regs[PROGRAM_SLOTS][0]));
  end

  // absolute value, saturated to the 8-bit error field
  assign magnitude = diff_q[DiffBits-1] ? DiffBits'(-diff_q) : DiffBits'(diff_q);

  always_comb begin
    rsp_d.result = result_q;
    rsp_d.halted = diff_halted_q;
    if (|magnitude[DiffBits-1:FIELD_BITS]) begin
      rsp_d.abs_error = '1;
    end else begin
      rsp_d.abs_error = magnitude[FIELD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* src/lpe_checker.sv */
// port-level checks of the linear program evaluator, bound to the top level
// depends on lpe_pkg and linear_program_evaluator_macros.svh
`include "linear_program_evaluator_macros.svh"

module lpe_checker #(
  parameter int unsigned PROGRAM_SLOTS = lpe_pkg::PROGRAM_SLOTS_DEFAULT
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input lpe_pkg::lpe_req_t req_i,
  input logic              done_o,
  input lpe_pkg::lpe_rsp_t rsp_o
);
  import lpe_pkg::*;

  localparam int unsigned Latency = PROGRAM_SLOTS + 2;

  // every accepted beat comes out after the fixed latency
  `LPE_ASSERT(a_latency, (start && !busy) |-> ##Latency done_o, "accepted beat lost")
  // no response beat without a request beat at the matching distance
  `LPE_ASSERT(a_no_spurious, done_o |-> $past(start && !busy, Latency), "spurious response")
  // an empty program cannot halt
  `LPE_ASSERT(a_empty_no_halt, (done_o && rsp_o.halted) |-> $past(req_i.length != 0, Latency), "empty program halted")
  // the pipeline takes a beat every cycle
  `LPE_ASSERT_NEVER(a_never_busy, busy, "busy raised")

endmodule

bind linear_program_evaluator lpe_checker #(.PROGRAM_SLOTS(PROGRAM_SLOTS)) u_lpe_checker (.*);

/* sim/lpe_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the linear program evaluator: watches both channels,
// runs each accepted program beat and compares the returned beats in order
// depends on lpe_pkg
module lpe_result_checker #(
  parameter int unsigned PROGRAM_SLOTS = lpe_pkg::PROGRAM_SLOTS_DEFAULT,
  parameter int unsigned VALUE_BITS    = lpe_pkg::VALUE_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  lpe_pkg::lpe_req_t req_i,
  input  logic              done_i,
  input  lpe_pkg::lpe_rsp_t rsp_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       outstanding_o
);
  import lpe_pkg::*;

  localparam int unsigned MAX_PRINTED = 200;

  lpe_rsp_t    pending_results[$];
  int unsigned mismatches;

  // two's complement wrap at the datapath width
  function automatic int wrap_value(int v);
    logic signed [VALUE_BITS-1:0] t;
    t = v[VALUE_BITS-1:0];
    return int'(t);
  endfunction

  function automatic lpe_rsp_t run_program(lpe_req_t r);
    logic [63:0]           code;
    logic [SLOT_BITS-1:0]  word;
    lpe_op_e               op;
    int unsigned           len;
    int unsigned           dst;
    int unsigned           src;
    int                    regs[REG_COUNT];
    int                    consts[REG_COUNT];
    int                    ret;
    int                    diff;
    bit                    stopped;
    lpe_rsp_t              rsp;
    code      = 64'(r.program_req);
    consts[0] = wrap_value(int'($signed(r.const_zero)));
    consts[1] = wrap_value(int'($signed(r.const_one)));
    consts[2] = wrap_value(int'($signed(r.const_two)));
    consts[3] = wrap_value(int'($signed(r.const_three)));
    regs[0]   = wrap_value(int'($signed(r.input_a)));
    regs[1]   = wrap_value(int'($signed(r.input_b)));
    regs[2]   = 0;
    regs[3]   = 0;
    len       = (32'(r.length) > PROGRAM_SLOTS) ? PROGRAM_SLOTS : 32'(r.length);
    stopped   = 1'b0;
    ret       = 0;
    for (int unsigned pc = 0; pc < len && !stopped; pc++) begin
      // slots past the packed field read as zero
      word = SLOT_BITS'(code >> (SLOT_BITS * pc));
      op   = lpe_op_e'(word[2:0]);
      dst  = 32'(word[4:3]);
      src  = 32'(word[6:5]);
      case (op)
        OP_ADD:  regs[dst] = wrap_value(regs[dst] + regs[src]);
        OP_SUB:  regs[dst] = wrap_value(regs[dst] - regs[src]);
        OP_LDIM: regs[dst] = consts[src];
        OP_SHL:  regs[dst] = wrap_value(regs[dst] * 2);
        OP_SHR:  regs[dst] = regs[dst] >>> 1;
        OP_HALT: begin
          ret     = regs[dst];
          stopped = 1'b1;
        end
        default: ;
      endcase
    end
    if (!stopped) ret = regs[0];
    diff = ret - int'($signed(r.expected));
    if (diff < 0) diff = -diff;
    if (diff > 255) diff = 255;
    rsp.result    = FIELD_BITS'(ret);
    rsp.abs_error = FIELD_BITS'(diff);
    rsp.halted    = stopped;
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lpe_rsp_t want;
    if (!rst_ni) begin
      pending_results.delete();
      mismatches     = 0;
      mismatch_cnt_o <= 0;
      outstanding_o  <= 0;
    end else begin
      if (start_i && !busy_i) pending_results.push_back(run_program(req_i));
      if (done_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with no program pending");
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.result !== want.result)
            report_mismatch($sformatf("result %0d, want %0d",
                                      $signed(rsp_i.result), $signed(want.result)));
          if (rsp_i.abs_error !== want.abs_error)
            report_mismatch($sformatf("abs_error %0d, want %0d",
                                      rsp_i.abs_error, want.abs_error));
          if (rsp_i.halted !== want.halted)
            report_mismatch($sformatf("halted %b, want %b", rsp_i.halted, want.halted));
        end
      end
      mismatch_cnt_o <= mismatches;
      outstanding_o  <= pending_results.size();
    end
  end

endmodule

/* sim/linear_program_evaluator_tb.sv */
`timescale 1ns / 100ps
// testbench top for the linear program evaluator: clock, reset, program
// beats with random gaps, watchdog and verdict
// depends on lpe_pkg, linear_program_evaluator and lpe_result_checker
module linear_program_evaluator_tb;
  import lpe_pkg::*;

  localparam int unsigned PROGRAM_SLOTS  = PROGRAM_SLOTS_DEFAULT;
  localparam int unsigned VALUE_BITS     = VALUE_BITS_DEFAULT;
  localparam int unsigned LATENCY        = PROGRAM_SLOTS + 2;
  localparam int unsigned RANDOM_BEATS   = 1700;
  // the last stretch of the run goes back to back
  localparam int unsigned STEADY_TAIL    = 200;
  // worst honest quiet stretch is the longest random gap plus the pipeline
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  lpe_req_t    req_i;
  logic        done_o;
  lpe_rsp_t    rsp_o;
  int unsigned mismatch_cnt;
  int unsigned outstanding;
  int unsigned quiet_cycles;

  linear_program_evaluator #(
    .PROGRAM_SLOTS(PROGRAM_SLOTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  lpe_result_checker #(
    .PROGRAM_SLOTS(PROGRAM_SLOTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .done_i        (done_o),
    .rsp_i         (rsp_o),
    .mismatch_cnt_o(mismatch_cnt),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog: any accepted beat on either side restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one packed instruction slot: src in the top bits, opcode in the bottom
  function automatic logic [SLOT_BITS-1:0] insn(lpe_op_e op, int unsigned dst,
                                                int unsigned src);
    return {src[1:0], dst[1:0], op};
  endfunction

  // random field value, leaning on the corners now and then
  function automatic logic [FIELD_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 8'h80;
      1:       return 8'h7f;
      2:       return 8'hff;
      3:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic lpe_req_t rand_req();
    lpe_req_t    r;
    int unsigned style;
    int unsigned halt_slot;
    r.program_req = PROGRAM_BITS'({$urandom, $urandom});
    style         = $urandom_range(0, 9);
    halt_slot     = $urandom_range(0, PROGRAM_SLOTS - 1);
    // raw random code halts early most of the time, so a good share of
    // programs get their halts stripped or placed at a chosen slot
    if (style >= 5) begin
      for (int unsigned s = 0; s < PROGRAM_SLOTS; s++) begin
        if (style >= 8 && s == halt_slot)
          r.program_req[SLOT_BITS*s +: 3] = OP_HALT;
        else if (r.program_req[SLOT_BITS*s +: 3] == OP_HALT)
          r.program_req[SLOT_BITS*s +: 3] = 3'($urandom_range(0, 6));
      end
    end
    // lengths past the slot count show up now and then
    r.length      = ($urandom_range(0, 3) == 0) ? LENGTH_BITS'($urandom_range(0, 15))
                                                : LENGTH_BITS'($urandom_range(1, 8));
    r.const_zero  = rand_value();
    r.const_one   = rand_value();
    r.const_two   = rand_value();
    r.const_three = rand_value();
    r.input_a     = rand_value();
    r.input_b     = rand_value();
    r.expected    = rand_value();
    return r;
  endfunction

  // present one program beat and hold it until the block takes it;
  // start is left high so a following beat goes out back to back
  task automatic send_beat(lpe_req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // directed beat with random constants
  task automatic send_case(logic [PROGRAM_BITS-1:0] prog, int unsigned len, int a, int b,
                           int want);
    lpe_req_t r;
    r             = rand_req();
    r.program_req = prog;
    r.length      = LENGTH_BITS'(len);
    r.input_a     = FIELD_BITS'(a);
    r.input_b     = FIELD_BITS'(b);
    r.expected    = FIELD_BITS'(want);
    send_beat(r);
  endtask

  // drop start for a burst; the payload wanders so stale data is ignored
  task automatic idle_for(int unsigned cycles);
    start <= 1'b0;
    req_i <= rand_req();
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    lpe_req_t r;
    bit       gaps_on;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part; in the concatenations slot 0 is the rightmost ---
    // empty program returns input_a, error at its widest both ways
    send_case('0, 0, -128, 5, 127);
    send_case('0, 0, 127, -3, -128);
    // add and subtract wrapping past the signed range
    send_case(PROGRAM_BITS'({insn(OP_HALT, 0, 0), insn(OP_ADD, 0, 1)}), 2, 127, 127, 0);
    send_case(PROGRAM_BITS'(insn(OP_SUB, 0, 1)), 1, -128, 1, -128);
    // shift left out of the top, with and without a halt on register 1
    send_case(PROGRAM_BITS'({insn(OP_HALT, 1, 0), insn(OP_SHL, 1, 0), insn(OP_SHL, 0, 0)}),
              3, 127, -128, 0);
    send_case(PROGRAM_BITS'({insn(OP_HALT, 1, 0), insn(OP_SHL, 1, 0), insn(OP_SHL, 0, 0)}),
              2, 127, -128, 0);
    // arithmetic shift right rounds toward minus infinity
    send_case(PROGRAM_BITS'(insn(OP_SHR, 0, 0)), 1, -1, 0, 0);
    send_case(PROGRAM_BITS'(insn(OP_SHR, 0, 0)), 1, -127, 0, 0);
    send_case(PROGRAM_BITS'(insn(OP_SHR, 0, 0)), 1, 127, 0, -128);
    // each constant select loaded into its own register, then summed into r0
    r             = rand_req();
    r.program_req = PROGRAM_BITS'({insn(OP_ADD, 0, 3), insn(OP_ADD, 0, 2), insn(OP_ADD, 0, 1),
                                   insn(OP_LDIM, 3, 3), insn(OP_LDIM, 2, 2),
                                   insn(OP_LDIM, 1, 1), insn(OP_LDIM, 0, 0)});
    r.length      = LENGTH_BITS'(7);
    r.const_zero  = 8'h80;
    r.const_one   = 8'h7f;
    r.const_two   = 8'hff;
    r.const_three = 8'h01;
    send_beat(r);
    // jump-if-zero and nop only: falls off the end with input_a
    send_case({4{insn(OP_NOP, 2, 3), insn(OP_JMPIFZ, 1, 0)}}, 8, 42, 0, -42);
    // halt on each register in slot 0
    for (int unsigned d = 0; d < REG_COUNT; d++)
      send_case(PROGRAM_BITS'(insn(OP_HALT, d, 0)), 1, -7, 99, 3);
    // halt in the last slot, reached and just out of reach
    send_case(PROGRAM_BITS'(insn(OP_HALT, 1, 0)) << (SLOT_BITS * 7), 8, 1, -100, 100);
    send_case(PROGRAM_BITS'(insn(OP_HALT, 1, 0)) << (SLOT_BITS * 7), 7, 1, -100, 100);
    // oversized lengths clamp to the slot count: eight doublings of 3 wrap to 0
    send_case('0, 9, 3, 0, 0);
    send_case('0, 15, 3, 0, 0);
    // all-ones code: halt on register 3, still zero
    send_case('1, 8, -128, 127, -128);

    // --- random part ---
    gaps_on = 1'b1;
    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      send_beat(rand_req());
      // stretches with and without gaps, none in the tail
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i < RANDOM_BEATS - STEADY_TAIL && gaps_on && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 19));
    end
    start <= 1'b0;

    // drain: the checker's count is registered, so step before looking
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    // a little extra so a stray late beat is still caught
    repeat (LATENCY + 4) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* linear_program_evaluator.f */
+incdir+src
src/lpe_pkg.sv
src/lpe_slot.sv
src/linear_program_evaluator.sv
src/lpe_checker.sv
sim/lpe_result_checker.sv
sim/linear_program_evaluator_tb.sv
